// ----- design/char_lcd_nibble_write_sequencer_top_defines.svh -----
// ---------------------------------------------------------------------------
// Character LCD nibble write sequencer: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define CLNWS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked only out of reset.
`define CLNWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/clnws_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Character LCD nibble write sequencer package
// Shared widths, request codes, the queued operation type and lookup tables.
// ---------------------------------------------------------------------------
package clnws_pkg;

	localparam int TIMER_BITS  = 16;
	localparam int STROBE_W    = 8;
	localparam int TICKS_W     = 16;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int STEP_W      = 4;
	localparam int INIT_COUNT  = 9;
	localparam int IN_TDATA_W  = 24;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 8;
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);

	// Output item bit positions
	localparam int OUT_RS_BIT   = 0;
	localparam int OUT_EN_BIT   = 1;
	localparam int OUT_DATA_LSB = 2;
	localparam int OUT_BUSY_BIT = 6;
	localparam int OUT_ACC_BIT  = 7;

	localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

	// Configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_STROBE     = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_POWER_ON   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_INIT_WAIT  = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_CLEAR_WAIT = 2'd3;

	typedef logic [TIMER_BITS-1:0] timer_t;

	typedef enum logic [2:0] {
		REQ_TICK = 3'd0,
		REQ_CMD  = 3'd1,
		REQ_DATA = 3'd2,
		REQ_POS  = 3'd3,
		REQ_INIT = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_BYTE,
		KIND_INIT
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic       rs;
		logic [7:0] value;
	} op_t;

	function automatic logic [7:0] init_cmd(input logic [STEP_W-1:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0, 4'd1: c = 8'h33;
			4'd2:       c = 8'h32;
			4'd3:       c = 8'h28;
			4'd4:       c = 8'h08;
			4'd5:       c = 8'h01;
			4'd6:       c = 8'h06;
			4'd7, 4'd8: c = 8'h0c;
			default:    c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		unique case (r)
			2'd0: b = 8'h80;
			2'd1: b = 8'hc0;
			2'd2: b = 8'h94;
			default: b = 8'hd4;
		endcase
		return b;
	endfunction

	// A zero count acts as one; a count beyond the timer saturates.
	function automatic timer_t load_count(input logic [TICKS_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (v == '0) begin
			w = 32'd1;
		end
		if (w > TIMER_MAX) begin
			w = TIMER_MAX;
		end
		return w[TIMER_BITS-1:0];
	endfunction

endpackage

// ----- design/char_lcd_nibble_write_sequencer_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Character LCD nibble write sequencer, top level
// Drives a 4-bit parallel character display interface from timebase ticks.
// ---------------------------------------------------------------------------
// Every input item is one timebase tick, optionally carrying a request, and
// yields exactly one output item with the pin levels after that tick. The
// block takes one item per clock in steady state while the output is not
// stalled; an item passes through the decoder register, then the operation
// queue and then the output register. The rate is set by the sequencer,
// which applies one tick per clock unless the output holds the item. A
// request is only taken when the sequencer was idle at the start of its
// tick; otherwise the item only advances the running transfer.
// Configuration writes must be made while no ticks are in flight.
module char_lcd_nibble_write_sequencer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [clnws_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [clnws_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// byte_value[7:0], row[10:8], column[18:11], zero fill [23:19]
	input  logic [clnws_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// req_type[2:0]
	input  logic [clnws_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// pin_rs[0], pin_en[1], pin_data[5:2], busy_res[6], accepted[7]
	output logic [clnws_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic           dec_valid;
	logic           dec_ready;
	clnws_pkg::op_t dec_op;
	logic           q_valid;
	logic           q_ready;
	clnws_pkg::op_t q_op;

	clnws_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.op_valid      (dec_valid),
		.op_data       (dec_op),
		.op_ready      (dec_ready)
	);

	clnws_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_data   (dec_op),
		.in_ready  (dec_ready),
		.out_valid (q_valid),
		.out_data  (q_op),
		.out_ready (q_ready)
	);

	clnws_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.op_valid      (q_valid),
		.op_data       (q_op),
		.op_ready      (q_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ----- design/clnws_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Operation queue
// Short FIFO between the request decoder and the pin sequencer.
// ---------------------------------------------------------------------------
module clnws_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  clnws_pkg::op_t    in_data,
	output logic              in_ready,
	output logic              out_valid,
	output clnws_pkg::op_t    out_data,
	input  logic              out_ready
);

	clnws_pkg::op_t                mem_q [clnws_pkg::Q_DEPTH];
	logic [clnws_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [clnws_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [clnws_pkg::Q_PTR_W:0]   count_q;
	logic                          push;
	logic                          pop;

	assign in_ready  = (count_q != (clnws_pkg::Q_PTR_W+1)'(clnws_pkg::Q_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/clnws_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Request decoder
// Takes input items, classifies each request and forms the byte to send.
// ---------------------------------------------------------------------------
module clnws_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// byte_value[7:0], row[10:8], column[18:11], zero fill [23:19]
	input  logic [clnws_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// req_type[2:0]
	input  logic [clnws_pkg::IN_TUSER_W-1:0] s_axis_tuser,
	output logic                             op_valid,
	output clnws_pkg::op_t                   op_data,
	input  logic                             op_ready
);

	logic           valid_s1;
	clnws_pkg::op_t op_s1;
	clnws_pkg::op_t op_c;
	logic [7:0]     byte_value;
	logic [2:0]     row;
	logic [7:0]     column;

	assign byte_value = s_axis_tdata[7:0];
	assign row        = s_axis_tdata[10:8];
	assign column     = s_axis_tdata[18:11];

	always_comb begin
		op_c.kind  = clnws_pkg::KIND_NONE;
		op_c.rs    = 1'b0;
		op_c.value = byte_value;
		unique case (clnws_pkg::req_t'(s_axis_tuser))
			clnws_pkg::REQ_CMD: begin
				op_c.kind = clnws_pkg::KIND_BYTE;
			end
			clnws_pkg::REQ_DATA: begin
				op_c.kind = clnws_pkg::KIND_BYTE;
				op_c.rs   = 1'b1;
			end
			clnws_pkg::REQ_POS: begin
				// Rows above three are dropped as a plain tick.
				if (!row[2]) begin
					op_c.kind  = clnws_pkg::KIND_BYTE;
					op_c.value = clnws_pkg::row_base(row[1:0]) + {3'b000, column[4:0]};
				end
			end
			clnws_pkg::REQ_INIT: begin
				op_c.kind = clnws_pkg::KIND_INIT;
			end
			default: begin
				op_c.kind = clnws_pkg::KIND_NONE;
			end
		endcase
	end

	assign s_axis_tready = !valid_s1 || op_ready;
	assign op_valid      = valid_s1;
	assign op_data       = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			op_s1 <= op_c;
		end
	end

endmodule

// ----- design/clnws_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pin sequencer
// Runs one timebase tick per queued item and registers the pin levels.
// ---------------------------------------------------------------------------
module clnws_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [clnws_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [clnws_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                              op_valid,
	input  clnws_pkg::op_t                    op_data,
	output logic                              op_ready,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [clnws_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_POWER,
		PH_HIGH,
		PH_LOW,
		PH_POST
	} phase_t;

	logic [clnws_pkg::STROBE_W-1:0] strobe_q;
	logic [clnws_pkg::TICKS_W-1:0]  power_q;
	logic [clnws_pkg::TICKS_W-1:0]  init_wait_q;
	logic [clnws_pkg::TICKS_W-1:0]  clear_wait_q;

	phase_t                       phase_q, phase_d;
	clnws_pkg::timer_t            timer_q, timer_d;
	logic [7:0]                   shift_q, shift_d;
	logic                         low_q, low_d;
	logic                         rs_q, rs_d;
	logic                         en_q, en_d;
	logic [3:0]                   nib_q, nib_d;
	logic [clnws_pkg::STEP_W-1:0] step_q, step_d;
	logic                         acc_d;

	logic                          start_en;
	logic [7:0]                    start_val;
	logic                          start_rs;
	logic [clnws_pkg::TICKS_W-1:0] wait_w;
	logic [clnws_pkg::TICKS_W-1:0] strobe_w;
	logic                          pop;
	logic                          out_valid_q;
	logic [clnws_pkg::OUT_TDATA_W-1:0] out_data_q;

	assign strobe_w = {{(clnws_pkg::TICKS_W-clnws_pkg::STROBE_W){1'b0}}, strobe_q};

	// Wait after the init command now in flight; zero skips the wait.
	always_comb begin
		unique case (step_q)
			4'd1:    wait_w = init_wait_q;
			4'd6:    wait_w = clear_wait_q;
			4'd8:    wait_w = '0;
			default: wait_w = strobe_w;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_q;
		shift_d   = shift_q;
		low_d     = low_q;
		rs_d      = rs_q;
		en_d      = en_q;
		nib_d     = nib_q;
		step_d    = step_q;
		acc_d     = 1'b0;
		start_en  = 1'b0;
		start_val = 8'h00;
		start_rs  = 1'b0;
		if (phase_q == PH_IDLE) begin
			unique case (op_data.kind)
				clnws_pkg::KIND_BYTE: begin
					start_en  = 1'b1;
					start_val = op_data.value;
					start_rs  = op_data.rs;
					acc_d     = 1'b1;
				end
				clnws_pkg::KIND_INIT: begin
					step_d  = '0;
					en_d    = 1'b0;
					phase_d = PH_POWER;
					timer_d = clnws_pkg::load_count(power_q);
					acc_d   = 1'b1;
				end
				default: begin
					acc_d = 1'b0;
				end
			endcase
		end else if (timer_q > clnws_pkg::timer_t'(1)) begin
			timer_d = timer_q - clnws_pkg::timer_t'(1);
		end else begin
			timer_d = '0;
			unique case (phase_q)
				PH_POWER: begin
					step_d    = clnws_pkg::STEP_W'(1);
					start_en  = 1'b1;
					start_val = clnws_pkg::init_cmd('0);
				end
				PH_HIGH: begin
					en_d    = 1'b0;
					phase_d = PH_LOW;
					timer_d = clnws_pkg::load_count(strobe_w);
				end
				PH_LOW: begin
					if (!low_q) begin
						low_d   = 1'b1;
						nib_d   = shift_q[3:0];
						en_d    = 1'b1;
						phase_d = PH_HIGH;
						timer_d = clnws_pkg::load_count(strobe_w);
					end else begin
						en_d = 1'b0;
						if (step_q == '0) begin
							phase_d = PH_IDLE;
						end else if (wait_w != '0) begin
							phase_d = PH_POST;
							timer_d = clnws_pkg::load_count(wait_w);
						end else if (step_q < clnws_pkg::STEP_W'(clnws_pkg::INIT_COUNT)) begin
							step_d    = step_q + 1'b1;
							start_en  = 1'b1;
							start_val = clnws_pkg::init_cmd(step_q);
						end else begin
							step_d  = '0;
							phase_d = PH_IDLE;
						end
					end
				end
				PH_POST: begin
					if (step_q != '0 &&
					    step_q < clnws_pkg::STEP_W'(clnws_pkg::INIT_COUNT)) begin
						step_d    = step_q + 1'b1;
						start_en  = 1'b1;
						start_val = clnws_pkg::init_cmd(step_q);
					end else begin
						step_d  = '0;
						en_d    = 1'b0;
						phase_d = PH_IDLE;
					end
				end
				default: begin
					en_d    = 1'b0;
					step_d  = '0;
					phase_d = PH_IDLE;
				end
			endcase
		end
		// Starting a byte puts the high nibble out with enable raised.
		if (start_en) begin
			shift_d = start_val;
			rs_d    = start_rs;
			low_d   = 1'b0;
			nib_d   = start_val[7:4];
			en_d    = 1'b1;
			phase_d = PH_HIGH;
			timer_d = clnws_pkg::load_count(strobe_w);
		end
	end

	assign pop           = op_valid && (!out_valid_q || m_axis_tready);
	assign op_ready      = pop;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q     <= 8'd3;
			power_q      <= 16'd1000;
			init_wait_q  <= 16'd50;
			clear_wait_q <= 16'd30;
			phase_q      <= PH_IDLE;
			timer_q      <= '0;
			shift_q      <= '0;
			low_q        <= 1'b0;
			rs_q         <= 1'b0;
			en_q         <= 1'b0;
			nib_q        <= '0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					clnws_pkg::REG_STROBE:     strobe_q     <= cfg_wdata[clnws_pkg::STROBE_W-1:0];
					clnws_pkg::REG_POWER_ON:   power_q      <= cfg_wdata;
					clnws_pkg::REG_INIT_WAIT:  init_wait_q  <= cfg_wdata;
					clnws_pkg::REG_CLEAR_WAIT: clear_wait_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (pop) begin
				phase_q     <= phase_d;
				timer_q     <= timer_d;
				shift_q     <= shift_d;
				low_q       <= low_d;
				rs_q        <= rs_d;
				en_q        <= en_d;
				nib_q       <= nib_d;
				step_q      <= step_d;
				out_valid_q <= 1'b1;
				out_data_q  <= {acc_d, (phase_d != PH_IDLE), nib_d, en_d, rs_d};
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/clnws_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Port checker
// Watches the output stream of the sequencer top level over time.
// ---------------------------------------------------------------------------
`include "char_lcd_nibble_write_sequencer_top_defines.svh"

module clnws_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [clnws_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// A taken request always leaves the sequencer busy.
	`CLNWS_ASSERT_NOW(a_acc_busy, clk, arst_n, m_axis_tvalid && m_axis_tdata[clnws_pkg::OUT_ACC_BIT], m_axis_tdata[clnws_pkg::OUT_BUSY_BIT], "accepted item not busy")

	// The enable strobe is never high while idle.
	`CLNWS_ASSERT_NOW(a_idle_en_low, clk, arst_n, m_axis_tvalid && !m_axis_tdata[clnws_pkg::OUT_BUSY_BIT], !m_axis_tdata[clnws_pkg::OUT_EN_BIT], "enable high while idle")

	`CLNWS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output item changed")

endmodule

bind char_lcd_nibble_write_sequencer_top clnws_checker u_clnws_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
